>>> sv/ptc_pkg.sv
package ptc_pkg;

  localparam int DivW = 64;
  localparam int DenW = 33;

  localparam longint CAL_T1 = 27504;
  localparam longint CAL_T2 = 26435;
  localparam longint CAL_T3 = -1000;
  localparam longint CAL_P1 = 36477;
  localparam longint CAL_P2 = -10685;
  localparam longint CAL_P3 = 3024;
  localparam longint CAL_P4 = 2855;
  localparam longint CAL_P5 = 140;
  localparam longint CAL_P6 = -7;
  localparam longint CAL_P7 = 15500;
  localparam longint CAL_P8 = -14600;
  localparam longint CAL_P9 = 6000;

  localparam longint FINE_OFFSET = 128000;
  localparam longint RAW_FULL    = 1048576;
  localparam longint PRESS_MAX   = 33554431;
  localparam longint TEMP_MAX    = 32767;
  localparam longint TEMP_MIN    = -32768;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               zero;
    logic               neg;
  } div_meta_t;

  typedef struct packed {
    div_meta_t         meta;
    logic [DivW-1:0]   num_mag;
    logic [DenW-1:0]   den_mag;
  } front_out_t;

  typedef struct packed {
    div_meta_t         meta;
    logic [DivW-1:0]   quo;
  } div_out_t;

endpackage

>>> sv/ptc_in_if.sv
interface ptc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pressure_high_byte;
  logic [7:0] pressure_mid_byte;
  logic [7:0] pressure_low_byte;
  logic [7:0] temperature_high_byte;
  logic [7:0] temperature_mid_byte;
  logic [7:0] temperature_low_byte;

  modport source (
    output valid, pressure_high_byte, pressure_mid_byte, pressure_low_byte,
           temperature_high_byte, temperature_mid_byte, temperature_low_byte,
    input  ready
  );
  modport sink (
    input  valid, pressure_high_byte, pressure_mid_byte, pressure_low_byte,
           temperature_high_byte, temperature_mid_byte, temperature_low_byte,
    output ready
  );
endinterface

>>> sv/ptc_out_if.sv
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic [24:0]        pressure_q8;
  logic               divisor_zero;

  modport source (
    output valid, temperature_centi, pressure_q8, divisor_zero,
    input  ready
  );
  modport sink (
    input  valid, temperature_centi, pressure_q8, divisor_zero,
    output ready
  );
endinterface

>>> sv/ptc_front.sv
module ptc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [19:0]          adc_p,
  input  logic [19:0]          adc_t,
  output logic                 out_valid,
  output ptc_pkg::front_out_t  out_data
);

  localparam int NStg = 10;

  logic [NStg-1:0] v_r;

  logic        [19:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic signed [17:0] u_r;
  logic signed [16:0] d_r;
  logic signed [32:0] m1_r;
  logic signed [31:0] dd_r;
  logic signed [22:0] ta_r;
  logic signed [30:0] tb_r;
  logic signed [23:0] fine_r;
  logic signed [15:0] t5_r, t6_r, t7_r, t8_r, t9_r;
  logic signed [23:0] a1_r;
  logic signed [41:0] sq_r;
  logic signed [28:0] l5_r;
  logic signed [35:0] l2_r;
  logic signed [49:0] b_r;
  logic signed [49:0] a2_r;
  logic signed [63:0] denp_r;
  logic signed [53:0] num_r;
  logic signed [63:0] den_r;
  logic signed [63:0] num3_r;
  ptc_pkg::front_out_t out_r;

  logic signed [63:0] u_nxt, d_nxt, m1_nxt, dd_nxt, ta_nxt, tb_nxt, fine_nxt;
  logic signed [63:0] tw, t_nxt, a1_nxt, sq_nxt, l5_nxt, l2_nxt, b_nxt, a2_nxt;
  logic signed [63:0] denp_nxt, num_nxt, den_nxt, num3_nxt;
  logic [63:0] den_abs;

  always_comb begin
    u_nxt    = $signed({47'b0, adc_t[19:3]}) - 2 * ptc_pkg::CAL_T1;
    d_nxt    = $signed({48'b0, adc_t[19:4]}) - ptc_pkg::CAL_T1;
    m1_nxt   = 64'(u_r) * ptc_pkg::CAL_T2;
    dd_nxt   = 64'(d_r) * 64'(d_r);
    ta_nxt   = 64'(m1_r) >>> 11;
    tb_nxt   = (64'(dd_r) >>> 12) * ptc_pkg::CAL_T3;
    fine_nxt = 64'(ta_r) + (64'(tb_r) >>> 14);
    tw       = (64'(fine_r) * 5 + 128) >>> 8;
    if (tw > ptc_pkg::TEMP_MAX) begin
      t_nxt = ptc_pkg::TEMP_MAX;
    end else if (tw < ptc_pkg::TEMP_MIN) begin
      t_nxt = ptc_pkg::TEMP_MIN;
    end else begin
      t_nxt = tw;
    end
    a1_nxt   = 64'(fine_r) - ptc_pkg::FINE_OFFSET;
    sq_nxt   = 64'(a1_r) * 64'(a1_r);
    l5_nxt   = 64'(a1_r) * ptc_pkg::CAL_P5;
    l2_nxt   = 64'(a1_r) * ptc_pkg::CAL_P2;
    b_nxt    = 64'(sq_r) * ptc_pkg::CAL_P6 + (64'(l5_r) <<< 17)
             + (ptc_pkg::CAL_P4 <<< 35);
    a2_nxt   = ((64'(sq_r) * ptc_pkg::CAL_P3) >>> 8) + (64'(l2_r) <<< 12);
    denp_nxt = ((64'sd1 <<< 47) + 64'(a2_r)) * ptc_pkg::CAL_P1;
    num_nxt  = ((ptc_pkg::RAW_FULL - $signed({44'b0, p7_r})) <<< 31) - 64'(b_r);
    den_nxt  = denp_r >>> 33;
    num3_nxt = 64'(num_r) * 3125;
    den_abs  = den_r[63] ? 64'(-den_r) : 64'(den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NStg-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= adc_p;
      u_r    <= u_nxt[17:0];
      d_r    <= d_nxt[16:0];
      p2_r   <= p1_r;
      m1_r   <= m1_nxt[32:0];
      dd_r   <= dd_nxt[31:0];
      p3_r   <= p2_r;
      ta_r   <= ta_nxt[22:0];
      tb_r   <= tb_nxt[30:0];
      p4_r   <= p3_r;
      fine_r <= fine_nxt[23:0];
      p5_r   <= p4_r;
      t5_r   <= t_nxt[15:0];
      a1_r   <= a1_nxt[23:0];
      p6_r   <= p5_r;
      t6_r   <= t5_r;
      sq_r   <= sq_nxt[41:0];
      l5_r   <= l5_nxt[28:0];
      l2_r   <= l2_nxt[35:0];
      p7_r   <= p6_r;
      t7_r   <= t6_r;
      b_r    <= b_nxt[49:0];
      a2_r   <= a2_nxt[49:0];
      t8_r   <= t7_r;
      denp_r <= denp_nxt;
      num_r  <= num_nxt[53:0];
      t9_r   <= t8_r;
      den_r  <= den_nxt;
      num3_r <= num3_nxt;
      out_r.meta.temp <= t9_r;
      out_r.meta.zero <= (den_r == '0);
      out_r.meta.neg  <= num3_r[63] ^ den_r[63];
      out_r.num_mag   <= num3_r[63] ? 64'(-num3_r) : 64'(num3_r);
      out_r.den_mag   <= den_abs[ptc_pkg::DenW-1:0];
    end
  end

  assign out_valid = v_r[NStg-1];
  assign out_data  = out_r;

endmodule

>>> sv/ptc_div.sv
module ptc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ptc_pkg::front_out_t  in_data,
  output logic                 out_valid,
  output ptc_pkg::div_out_t    out_data
);

  localparam int N  = ptc_pkg::DivW;
  localparam int DW = ptc_pkg::DenW;

  logic [N-1:0]         v_r;
  logic [DW-1:0]        rem_r  [N];
  logic [N-1:0]         quo_r  [N];
  logic [DW-1:0]        den_r  [N];
  ptc_pkg::div_meta_t   meta_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DW-1:0]      rem_prev;
    logic [N-1:0]       quo_prev;
    logic [DW-1:0]      den_prev;
    ptc_pkg::div_meta_t meta_prev;
    logic [DW:0]        trial;
    logic               ge;
    logic [DW:0]        diff;

    if (i == 0) begin : g_first
      assign rem_prev  = '0;
      assign quo_prev  = in_data.num_mag;
      assign den_prev  = in_data.den_mag;
      assign meta_prev = in_data.meta;
    end else begin : g_next
      assign rem_prev  = rem_r[i-1];
      assign quo_prev  = quo_r[i-1];
      assign den_prev  = den_r[i-1];
      assign meta_prev = meta_r[i-1];
    end

    always_comb begin
      trial = {rem_prev, quo_prev[N-1]};
      ge    = (trial >= {1'b0, den_prev});
      diff  = ge ? (trial - {1'b0, den_prev}) : trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= diff[DW-1:0];
        quo_r[i]  <= {quo_prev[N-2:0], ge};
        den_r[i]  <= den_prev;
        meta_r[i] <= meta_prev;
      end
    end
  end

  assign out_valid     = v_r[N-1];
  assign out_data.meta = meta_r[N-1];
  assign out_data.quo  = quo_r[N-1];

endmodule

>>> sv/ptc_back.sv
module ptc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  ptc_pkg::div_out_t   in_data,
  output logic                out_valid,
  output logic signed [15:0]  temp,
  output logic [24:0]         press,
  output logic                zero
);

  localparam int NStg = 4;

  logic [NStg-1:0] v_r;

  logic signed [63:0] p1_r, p2_r, sq_r, bm_r, s_r;
  logic signed [15:0] t1_r, t2_r, t3_r, t_r;
  logic               z1_r, z2_r, z3_r, z_r;
  logic [24:0]        press_r;

  logic signed [63:0] p_nxt, x_nxt, sq_nxt, bm_nxt, s_nxt, r_nxt;
  logic signed [31:0] x32;
  logic [24:0]        press_nxt;

  always_comb begin
    p_nxt  = in_data.meta.neg ? -$signed(in_data.quo) : $signed(in_data.quo);
    x_nxt  = p1_r >>> 13;
    x32    = x_nxt[31:0];
    sq_nxt = 64'(x32) * 64'(x32);
    bm_nxt = p1_r * ptc_pkg::CAL_P8;
    s_nxt  = p2_r + ((sq_r * ptc_pkg::CAL_P9) >>> 25) + (bm_r >>> 19);
    r_nxt  = (s_r >>> 8) + ptc_pkg::CAL_P7 * 16;
    if (z3_r || r_nxt < 0) begin
      press_nxt = '0;
    end else if (r_nxt > ptc_pkg::PRESS_MAX) begin
      press_nxt = 25'(ptc_pkg::PRESS_MAX);
    end else begin
      press_nxt = r_nxt[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NStg-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p_nxt;
      t1_r    <= in_data.meta.temp;
      z1_r    <= in_data.meta.zero;
      p2_r    <= p1_r;
      sq_r    <= sq_nxt;
      bm_r    <= bm_nxt;
      t2_r    <= t1_r;
      z2_r    <= z1_r;
      s_r     <= s_nxt;
      t3_r    <= t2_r;
      z3_r    <= z2_r;
      press_r <= press_nxt;
      t_r     <= t3_r;
      z_r     <= z3_r;
    end
  end

  assign out_valid = v_r[NStg-1];
  assign temp      = t_r;
  assign press     = press_r;
  assign zero      = z_r;

endmodule

>>> sv/pressure_temperature_compensation.sv
// Compensates one raw sensor reading per word: temperature in signed hundredths of a degree
// and pressure in unsigned pascal times 256, both saturated, with fixed calibration.
// A new word is taken every cycle unless a finished result waits; each result passes
// through the ten front stages, the 64-stage restoring divider (one quotient bit per stage)
// and four back stages. The whole pipeline holds while a finished result waits to be taken.
module pressure_temperature_compensation (
  input  logic       clk,
  input  logic       rst_n,
  ptc_in_if.sink     in_chan,
  ptc_out_if.source  out_chan
);

  logic                en;
  logic                f_valid, d_valid, b_valid;
  ptc_pkg::front_out_t f_data;
  ptc_pkg::div_out_t   d_data;
  logic [19:0]         adc_p, adc_t;

  assign en    = !b_valid || out_chan.ready;
  assign in_chan.ready = en;

  assign adc_p = {in_chan.pressure_high_byte, in_chan.pressure_mid_byte,
                  in_chan.pressure_low_byte[7:4]};
  assign adc_t = {in_chan.temperature_high_byte, in_chan.temperature_mid_byte,
                  in_chan.temperature_low_byte[7:4]};

  ptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .adc_p     (adc_p),
    .adc_t     (adc_t),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_data   (d_data),
    .out_valid (b_valid),
    .temp      (out_chan.temperature_centi),
    .press     (out_chan.pressure_q8),
    .zero      (out_chan.divisor_zero)
  );

  assign out_chan.valid = b_valid;

endmodule
